// ===== rtl/cpnp_pkg.sv =====
// Shared codes for the collider pair narrow-phase block.
package cpnp_pkg;

    localparam int T_BITS = 16;

    localparam logic [1:0] KIND_SPHERE  = 2'd0;
    localparam logic [1:0] KIND_BOX     = 2'd1;
    localparam logic [1:0] KIND_CAPSULE = 2'd2;

    localparam logic [1:0] ST_FILTERED    = 2'd0;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd1;
    localparam logic [1:0] ST_MISS        = 2'd2;
    localparam logic [1:0] ST_HIT         = 2'd3;

    typedef enum logic [2:0] {
        PAIR_FILT,
        PAIR_UNSUP,
        PAIR_SS,
        PAIR_SB,
        PAIR_CS,
        PAIR_CB
    } pair_t;

endpackage

// ===== rtl/cpnp_pair_if.sv =====
// Input channel carrying one collider pair per item.
interface cpnp_pair_if #(
    parameter int COORD_BITS  = 21,
    parameter int FILTER_BITS = 16
);
    logic                       valid;
    logic                       ready;
    logic [1:0]                 a_kind;
    logic [1:0]                 b_kind;
    logic [2*FILTER_BITS-1:0]   a_filter;
    logic [2*FILTER_BITS-1:0]   b_filter;
    logic [3*COORD_BITS-1:0]    a_point;
    logic [3*COORD_BITS-1:0]    a_end;
    logic [COORD_BITS-2:0]      a_radius;
    logic [3*COORD_BITS-1:0]    b_point;
    logic [COORD_BITS-2:0]      b_radius;
    logic [3*COORD_BITS-1:0]    b_box_min;
    logic [3*COORD_BITS-1:0]    b_box_max;

    modport source (
        output valid, a_kind, b_kind, a_filter, b_filter, a_point, a_end, a_radius,
               b_point, b_radius, b_box_min, b_box_max,
        input  ready
    );
    modport sink (
        input  valid, a_kind, b_kind, a_filter, b_filter, a_point, a_end, a_radius,
               b_point, b_radius, b_box_min, b_box_max,
        output ready
    );
endinterface

// ===== rtl/cpnp_res_if.sv =====
// Output channel carrying one status item per pair.
interface cpnp_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       hit;

    modport source (output valid, status, hit, input ready);
    modport sink (input valid, status, hit, output ready);
endinterface

// ===== rtl/collision_pair_narrow_phase.sv =====
// Throughput: one pair per cycle while the output is not stalled; sixteen
// restoring-divider stages for the segment parameter set the depth.
// A stall at the output holds every stage; nothing is dropped or repeated.
// Reset (rst_n low, asynchronous) clears the valid bits only; the pipeline
// is empty and ready straight after reset.
module collision_pair_narrow_phase #(
    parameter int COORD_BITS  = 21,
    parameter int FILTER_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    cpnp_pair_if.sink   pair,
    cpnp_res_if.source  res
);
    import cpnp_pkg::*;

    localparam int CB  = COORD_BITS;
    localparam int FB  = FILTER_BITS;
    localparam int PW  = CB + 1;          // differences and box corners
    localparam int FW  = PW + 1;          // segment point
    localparam int NW  = 2 * PW + 2;      // signed dot products
    localparam int RW  = 2 * PW + 1;      // divider remainder
    localparam int TW  = T_BITS + 1;      // t in Q1.16 so that 1.0 fits
    localparam int MW  = PW + TW + 1;     // t * ba
    localparam int DW  = FW + 1;          // final difference
    localparam int SW  = 2 * DW + 2;      // sum of squares
    localparam int NST = 26;

    typedef struct {
        pair_t                  code;
        logic signed [CB-1:0]   s   [3];
        logic signed [CB-1:0]   bp  [3];
        logic signed [PW-1:0]   lo  [3];
        logic signed [PW-1:0]   hi  [3];
        logic signed [PW-1:0]   ba  [3];
        logic [CB-1:0]          rsel;
        logic [2*CB-1:0]        thr;
    } ctx_t;

    typedef struct {
        ctx_t                   ctx;
        logic [RW-1:0]          rem;
        logic [RW-2:0]          den;
        logic [T_BITS-1:0]      q;
        logic                   tz;
        logic                   to;
    } dv_t;

    function automatic logic signed [PW-1:0] sub_ext(logic signed [CB-1:0] x,
                                                     logic signed [CB-1:0] y);
        return PW'(x) - PW'(y);
    endfunction

    function automatic logic signed [PW-1:0] add_ext(logic signed [CB-1:0] x,
                                                     logic signed [CB-1:0] y);
        return PW'(x) + PW'(y);
    endfunction

    // Handshake: the whole pipe moves when the output slot is free or taken.
    logic           adv;
    logic [NST-1:0] vld_reg;

    assign adv        = !vld_reg[NST-1] || res.ready;
    assign pair.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NST-2:0], pair.valid};
        end
    end

    // Stage 1: filter, pair decode, segment vectors and box corners.
    ctx_t                  c1_next, c1_reg;
    logic signed [PW-1:0]  d1_next [3];
    logic signed [PW-1:0]  d1_reg  [3];

    always_comb
    begin
        logic [FB-1:0]         a_attr, a_mask, b_attr, b_mask;
        logic signed [CB-1:0]  ap, ae, bpt, mn, mx;
        logic                  pass;
        a_attr = pair.a_filter[2*FB-1:FB];
        a_mask = pair.a_filter[FB-1:0];
        b_attr = pair.b_filter[2*FB-1:FB];
        b_mask = pair.b_filter[FB-1:0];
        pass   = (|(a_attr & b_mask)) && (|(b_attr & a_mask));
        if (!pass)
            c1_next.code = PAIR_FILT;
        else if (pair.a_kind == KIND_SPHERE && pair.b_kind == KIND_SPHERE)
            c1_next.code = PAIR_SS;
        else if (pair.a_kind == KIND_SPHERE && pair.b_kind == KIND_BOX)
            c1_next.code = PAIR_SB;
        else if (pair.a_kind == KIND_CAPSULE && pair.b_kind == KIND_SPHERE)
            c1_next.code = PAIR_CS;
        else if (pair.a_kind == KIND_CAPSULE && pair.b_kind == KIND_BOX)
            c1_next.code = PAIR_CB;
        else
            c1_next.code = PAIR_UNSUP;
        for (int i = 0; i < 3; i++)
        begin
            ap  = $signed(pair.a_point[i*CB +: CB]);
            ae  = $signed(pair.a_end[i*CB +: CB]);
            bpt = $signed(pair.b_point[i*CB +: CB]);
            mn  = $signed(pair.b_box_min[i*CB +: CB]);
            mx  = $signed(pair.b_box_max[i*CB +: CB]);
            c1_next.s[i]  = ap;
            c1_next.bp[i] = bpt;
            c1_next.lo[i] = add_ext(bpt, mn);
            c1_next.hi[i] = add_ext(bpt, mx);
            c1_next.ba[i] = sub_ext(ae, ap);
            d1_next[i]    = sub_ext(bpt, ap);
        end
        // Box tests compare against ra alone, sphere tests against ra + rb.
        if (c1_next.code == PAIR_SB || c1_next.code == PAIR_CB)
            c1_next.rsel = {1'b0, pair.a_radius};
        else
            c1_next.rsel = CB'(pair.a_radius) + CB'(pair.b_radius);
        c1_next.thr = '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c1_reg <= c1_next;
            d1_reg <= d1_next;
        end
    end

    // Stage 2: per-axis products and the radius threshold.
    ctx_t                    c2_next, c2_reg;
    logic signed [2*PW-1:0]  pn2_reg [3];
    logic signed [2*PW-1:0]  pd2_reg [3];

    always_comb
    begin
        c2_next     = c1_reg;
        c2_next.thr = c1_reg.rsel * c1_reg.rsel;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c2_reg <= c2_next;
            for (int i = 0; i < 3; i++)
            begin
                pn2_reg[i] <= d1_reg[i] * c1_reg.ba[i];
                pd2_reg[i] <= c1_reg.ba[i] * c1_reg.ba[i];
            end
        end
    end

    // Stage 3: dot products.
    ctx_t                c3_reg;
    logic signed [NW-1:0] num3_reg;
    logic signed [NW-1:0] den3_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c3_reg   <= c2_reg;
            num3_reg <= NW'(pn2_reg[0]) + NW'(pn2_reg[1]) + NW'(pn2_reg[2]);
            den3_reg <= NW'(pd2_reg[0]) + NW'(pd2_reg[1]) + NW'(pd2_reg[2]);
        end
    end

    // Stage 4: settle the end cases of t, then one quotient bit per stage.
    dv_t dv_next [T_BITS+1];
    dv_t dv_reg  [T_BITS+1];

    always_comb
    begin
        logic capsule;
        capsule = (c3_reg.code == PAIR_CS) || (c3_reg.code == PAIR_CB);
        dv_next[0].ctx = c3_reg;
        dv_next[0].den = den3_reg[RW-2:0];
        dv_next[0].q   = '0;
        // A negative or zero dot product pins t to the segment start.
        dv_next[0].tz  = !capsule || den3_reg == '0 || num3_reg[NW-1] || num3_reg == '0;
        dv_next[0].to  = !dv_next[0].tz && num3_reg >= den3_reg;
        if (dv_next[0].tz || dv_next[0].to)
            dv_next[0].rem = '0;
        else
            dv_next[0].rem = num3_reg[RW-1:0];
        for (int k = 1; k <= T_BITS; k++)
        begin
            logic [RW-1:0] r2;
            logic          ge;
            r2 = {dv_reg[k-1].rem[RW-2:0], 1'b0};
            ge = r2 >= {1'b0, dv_reg[k-1].den};
            dv_next[k]     = dv_reg[k-1];
            dv_next[k].rem = ge ? r2 - {1'b0, dv_reg[k-1].den} : r2;
            dv_next[k].q   = {dv_reg[k-1].q[T_BITS-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_reg <= dv_next;
        end
    end

    // Stage t: scale the segment by t.
    ctx_t                 ct_reg;
    logic signed [MW-1:0] tb_reg [3];

    always_ff @(posedge clk)
    begin
        logic [TW-1:0] t;
        if (dv_reg[T_BITS].to)
            t = TW'(1) << T_BITS;
        else if (dv_reg[T_BITS].tz)
            t = '0;
        else
            t = {1'b0, dv_reg[T_BITS].q};
        if (adv)
        begin
            ct_reg <= dv_reg[T_BITS].ctx;
            for (int i = 0; i < 3; i++)
            begin
                tb_reg[i] <= $signed({1'b0, t}) * dv_reg[T_BITS].ctx.ba[i];
            end
        end
    end

    // Stage f: round half up and add the start point.
    ctx_t                 cf_reg;
    logic signed [FW-1:0] f_reg [3];

    always_ff @(posedge clk)
    begin
        logic signed [MW-1:0] rnd;
        if (adv)
        begin
            cf_reg <= ct_reg;
            for (int i = 0; i < 3; i++)
            begin
                rnd = (tb_reg[i] + (MW'(1) <<< (T_BITS - 1))) >>> T_BITS;
                f_reg[i] <= FW'(ct_reg.s[i]) + rnd[FW-1:0];
            end
        end
    end

    // Stage c: clamp the point to the box, max with lo first, then min with hi.
    ctx_t                 cc_reg;
    logic signed [FW-1:0] fc_reg [3];
    logic signed [FW-1:0] cl_reg [3];

    always_ff @(posedge clk)
    begin
        logic signed [FW-1:0] r;
        if (adv)
        begin
            cc_reg <= cf_reg;
            fc_reg <= f_reg;
            for (int i = 0; i < 3; i++)
            begin
                r = (f_reg[i] < FW'(cf_reg.lo[i])) ? FW'(cf_reg.lo[i]) : f_reg[i];
                cl_reg[i] <= (r > FW'(cf_reg.hi[i])) ? FW'(cf_reg.hi[i]) : r;
            end
        end
    end

    // Stage d: difference to the point that the test measures against.
    ctx_t                 cd_reg;
    logic signed [DW-1:0] df_reg [3];

    always_ff @(posedge clk)
    begin
        logic box;
        box = (cc_reg.code == PAIR_SB) || (cc_reg.code == PAIR_CB);
        if (adv)
        begin
            cd_reg <= cc_reg;
            for (int i = 0; i < 3; i++)
            begin
                if (box)
                    df_reg[i] <= DW'(cl_reg[i]) - DW'(fc_reg[i]);
                else
                    df_reg[i] <= DW'(cc_reg.bp[i]) - DW'(fc_reg[i]);
            end
        end
    end

    // Stage q: squares.
    ctx_t                   cq_reg;
    logic [2*DW-1:0]        sq_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cq_reg <= cd_reg;
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= (2*DW)'(df_reg[i] * df_reg[i]);
            end
        end
    end

    // Stage o: sum, compare and status; capsule-sphere is strict.
    logic [1:0] st_next, st_reg;
    logic       hit_reg;

    always_comb
    begin
        logic [SW-1:0] sum;
        logic          contact;
        sum = SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);
        if (cq_reg.code == PAIR_CS)
            contact = sum < SW'(cq_reg.thr);
        else
            contact = sum <= SW'(cq_reg.thr);
        case (cq_reg.code)
            PAIR_FILT:  st_next = ST_FILTERED;
            PAIR_UNSUP: st_next = ST_UNSUPPORTED;
            PAIR_SS, PAIR_SB, PAIR_CS, PAIR_CB:
                st_next = contact ? ST_HIT : ST_MISS;
            default:    st_next = ST_UNSUPPORTED;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg  <= st_next;
            hit_reg <= st_next == ST_HIT;
        end
    end

    assign res.valid  = vld_reg[NST-1];
    assign res.status = st_reg;
    assign res.hit    = hit_reg;

endmodule
